[rtl/hevcrtp_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// hevcrtp_pkg: shared types and constants of the H.265 RTP depacketizer
// Payload structs, the parser's element and queue entry formats, status
// codes, packet type codes and register indexes.
// ---------------------------------------------------------------------------
package hevcrtp_pkg;

   // width of the max NAL unit length register
   localparam int NALU_BITS = 22;
   localparam logic [NALU_BITS-1:0] NALU_RESET = 22'h3F_FFFF;

   // configuration bus
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam logic REG_MAX_NALU = 1'b0;
   localparam logic REG_EMIT_SC  = 1'b1;

   // status codes on a result
   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_MALFORMED   = 2'd1;
   localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
   localparam logic [1:0] ST_TOO_LONG    = 2'd3;

   // payload header type codes
   localparam logic [5:0] TYPE_SINGLE_MAX = 6'd47;
   localparam logic [5:0] TYPE_AGGR       = 6'd48;
   localparam logic [5:0] TYPE_FRAG       = 6'd49;

   // annex b start code
   localparam int START_CODE_BYTES = 4;
   localparam logic [8*START_CODE_BYTES-1:0] START_CODE = 32'h0000_0001;

   // depth of the queue between parser and expander
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_SINGLE = 2'd1,
      KIND_FRAG   = 2'd2,
      KIND_AGGR   = 2'd3
   } hevcrtp_kind_type;

   typedef enum logic [1:0] {
      PH_LEN_HI = 2'd0,
      PH_LEN_LO = 2'd1,
      PH_DATA   = 2'd2,
      PH_SKIP   = 2'd3
   } hevcrtp_phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       packet_first;
      logic       packet_last;
   } hevcrtp_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       unit_first;
      logic       unit_last;
      logic [1:0] status;
      logic       run_last;
   } hevcrtp_rsp_type;

   typedef struct packed {
      logic [NALU_BITS-1:0] max_nalu_bytes;
      logic                 emit_start_codes;
   } hevcrtp_cfg_type;

   // one parser element: an optional start code prefix, then one item
   typedef struct packed {
      logic       sc;
      logic [7:0] data;
      logic       valid;
      logic       first;
      logic       last;
      logic [1:0] status;
   } hevcrtp_elem_type;

   // all elements caused by one input byte (one or two)
   typedef struct packed {
      logic             two;
      hevcrtp_elem_type e1;
      hevcrtp_elem_type e0;
   } hevcrtp_entry_type;

   // element that ends the open unit
   function automatic hevcrtp_elem_type close_elem(input logic [1:0] st,
                                                   input logic cnt_zero,
                                                   input logic emit);
      hevcrtp_elem_type e;
      e = '0;
      e.last = 1'b1;
      if (st == ST_OK && cnt_zero && emit) begin
         e.sc = 1'b1;
      end else begin
         e.first  = cnt_zero;
         e.status = st;
      end
      return e;
   endfunction

   // byte i of the start code, most significant first
   function automatic logic [7:0] sc_byte(input logic [1:0] i);
      logic [8*START_CODE_BYTES-1:0] sh;
      sh = START_CODE >> (8 * (START_CODE_BYTES - 1 - int'(i)));
      return sh[7:0];
   endfunction

endpackage
`default_nettype wire

[rtl/hevc_rtp_depacketizer_top.sv]
`default_nettype none
// A byte's results pass through the entry queue and the registered result stage.
// Throughput: one payload byte per cycle in while the queue has room; the expander
// sends one result per cycle while its result stage is empty or popped, up to six
// per byte; a four-entry queue absorbs start code bursts before the input stalls.
// Reset: synchronous, clears parser state, queue and result stage, and returns
// max_nalu_bytes to 4194303 and emit_start_codes to 0.
// ---------------------------------------------------------------------------
// hevc_rtp_depacketizer_top: H.265 RTP payload depacketizer
// Parser front, entry queue and result expander with a register interface.
// ---------------------------------------------------------------------------
module hevc_rtp_depacketizer_top #(
   parameter int COUNT_BITS = 22
) (
   input  wire                                        clock,
   input  wire                                        reset,
   input  wire                                        push,
   output logic                                       full,
   input  hevcrtp_pkg::hevcrtp_req_type               req_item,
   output logic                                       empty,
   input  wire                                        pop,
   output hevcrtp_pkg::hevcrtp_rsp_type               rsp_item,
   input  wire                                        psel,
   input  wire                                        penable,
   input  wire                                        pwrite,
   input  wire [hevcrtp_pkg::CSR_ADDR_BITS-1:0]       paddr,
   input  wire [hevcrtp_pkg::CSR_DATA_BITS-1:0]       pwdata,
   output logic [hevcrtp_pkg::CSR_DATA_BITS-1:0]      prdata,
   output logic                                       pready
);
   import hevcrtp_pkg::*;

   hevcrtp_cfg_type    cfg_ff;
   logic               csr_write;
   logic               accept;
   logic               q_push;
   logic               q_pop;
   logic               q_full;
   logic               q_empty;
   hevcrtp_entry_type  q_wr_entry;
   hevcrtp_entry_type  q_head;

   // register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_nalu_bytes   <= NALU_RESET;
         cfg_ff.emit_start_codes <= 1'b0;
      end else if (csr_write) begin
         unique case (paddr[2])
            REG_MAX_NALU: cfg_ff.max_nalu_bytes   <= pwdata[NALU_BITS-1:0];
            REG_EMIT_SC:  cfg_ff.emit_start_codes <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_MAX_NALU: prdata = CSR_DATA_BITS'(cfg_ff.max_nalu_bytes);
         REG_EMIT_SC:  prdata = CSR_DATA_BITS'(cfg_ff.emit_start_codes);
         default:      prdata = '0;
      endcase
   end

   // input handshake
   assign full   = q_full;
   assign accept = push && !q_full;

   hevcrtp_front #(
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .item    (req_item),
      .accept  (accept),
      .q_push  (q_push),
      .q_entry (q_wr_entry)
   );

   hevcrtp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_push),
      .wr_entry (q_wr_entry),
      .full     (q_full),
      .rd_en    (q_pop),
      .rd_entry (q_head),
      .empty    (q_empty)
   );

   hevcrtp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (q_head),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .rsp_item (rsp_item),
      .empty    (empty),
      .pop      (pop)
   );

endmodule
`default_nettype wire

[rtl/hevcrtp_front.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// hevcrtp_front: packet parser
// Classifies each payload byte by packet type and header position and turns
// it into zero, one or two elements for the expander queue.
// ---------------------------------------------------------------------------
module hevcrtp_front #(
   parameter int COUNT_BITS = 22
) (
   input  wire                               clock,
   input  wire                               reset,
   input  hevcrtp_pkg::hevcrtp_cfg_type      cfg,
   input  hevcrtp_pkg::hevcrtp_req_type      item,
   input  wire                               accept,
   output logic                              q_push,
   output hevcrtp_pkg::hevcrtp_entry_type    q_entry
);
   import hevcrtp_pkg::*;

   localparam int CmpW = (COUNT_BITS > NALU_BITS) ? COUNT_BITS : NALU_BITS;
   localparam logic [CmpW-1:0] CountMask = {CmpW{1'b1}} >> (CmpW - COUNT_BITS);
   localparam logic [1:0] HdrDone = 2'd3;

   typedef struct packed {
      hevcrtp_elem_type       el;
      logic [COUNT_BITS-1:0]  cnt;
      logic                   ok;
   } ub_type;

   // parser state
   hevcrtp_kind_type        kind_ff, kind_in;
   logic [1:0]              pos_ff, pos_in;
   logic [7:0]              hdr1_ff, hdr1_in;
   logic [7:0]              hdr2_ff, hdr2_in;
   logic                    infrag_ff, infrag_in;
   logic                    fend_ff, fend_in;
   hevcrtp_phase_type       phase_ff, phase_in;
   logic [15:0]             rem_ff, rem_in;
   logic [7:0]              lenhi_ff, lenhi_in;
   logic [COUNT_BITS-1:0]   cnt_ff, cnt_in;

   logic [CmpW-1:0]         limit;
   hevcrtp_elem_type        el_v [2];
   logic [1:0]              n_v;
   logic                    ignore_v;
   logic [5:0]              type_v;
   logic                    fail_v;
   ub_type                  ub_v;
   ub_type                  ub2_v;

   // length limit clamped to the counter range
   always_comb begin
      if (CmpW'(cfg.max_nalu_bytes) > CountMask) begin
         limit = CountMask;
      end else begin
         limit = CmpW'(cfg.max_nalu_bytes);
      end
   end

   // one nal byte, or the over-length end when the limit is reached
   function automatic ub_type unit_byte(input logic [7:0] b, input logic last,
                                        input logic [COUNT_BITS-1:0] cnt,
                                        input logic [CmpW-1:0] lim,
                                        input logic emit);
      ub_type r;
      logic   first;
      first = (cnt == '0);
      r = '0;
      if (CmpW'(cnt) >= lim) begin
         r.el.first  = first;
         r.el.last   = 1'b1;
         r.el.status = ST_TOO_LONG;
         r.cnt       = '0;
         r.ok        = 1'b0;
      end else begin
         r.el.sc    = first && emit;
         r.el.data  = b;
         r.el.valid = 1'b1;
         r.el.first = first && !emit;
         r.el.last  = last;
         r.cnt      = last ? '0 : cnt + 1'b1;
         r.ok       = 1'b1;
      end
      return r;
   endfunction

   // next state and elements for the offered byte
   always_comb begin
      kind_in   = kind_ff;
      pos_in    = pos_ff;
      hdr1_in   = hdr1_ff;
      hdr2_in   = hdr2_ff;
      infrag_in = infrag_ff;
      fend_in   = fend_ff;
      phase_in  = phase_ff;
      rem_in    = rem_ff;
      lenhi_in  = lenhi_ff;
      cnt_in    = cnt_ff;
      el_v[0]   = '0;
      el_v[1]   = '0;
      n_v       = 2'd0;
      ignore_v  = 1'b0;
      type_v    = item.in_byte[6:1];
      fail_v    = 1'b0;
      ub_v      = '0;
      ub2_v     = '0;

      // packet start, with abort of an unfinished packet
      if (item.packet_first) begin
         if (pos_in != 2'd0) begin
            if (kind_in == KIND_SINGLE || (kind_in == KIND_AGGR && phase_in == PH_DATA) ||
                infrag_in) begin
               el_v[n_v[0]] = close_elem(ST_MALFORMED, cnt_in == '0,
                                         cfg.emit_start_codes);
               n_v = n_v + 2'd1;
            end
            infrag_in = 1'b0;
            cnt_in    = '0;
         end
         kind_in = KIND_NONE;
         pos_in  = 2'd0;
      end else if (pos_in == 2'd0) begin
         ignore_v = 1'b1;
      end

      if (!ignore_v) begin
         if (pos_in == 2'd0) begin
            // payload header first byte
            hdr1_in  = item.in_byte;
            pos_in   = 2'd1;
            phase_in = PH_LEN_HI;
            rem_in   = '0;
            if (infrag_in && type_v != TYPE_FRAG) begin
               el_v[n_v[0]] = close_elem(ST_MALFORMED, cnt_in == '0, cfg.emit_start_codes);
               n_v = n_v + 2'd1;
               cnt_in    = '0;
               infrag_in = 1'b0;
            end
            if (type_v <= TYPE_SINGLE_MAX) begin
               kind_in = KIND_SINGLE;
               ub_v = unit_byte(item.in_byte, item.packet_last, cnt_in, limit,
                                cfg.emit_start_codes);
               el_v[n_v[0]] = ub_v.el;
               n_v = n_v + 2'd1;
               cnt_in = ub_v.cnt;
               if (!ub_v.ok) kind_in = KIND_NONE;
            end else if (type_v == TYPE_FRAG) begin
               kind_in = KIND_FRAG;
            end else if (type_v == TYPE_AGGR) begin
               kind_in = KIND_AGGR;
            end else begin
               el_v[n_v[0]] = close_elem(ST_UNSUPPORTED, cnt_in == '0, cfg.emit_start_codes);
               n_v = n_v + 2'd1;
               cnt_in  = '0;
               kind_in = KIND_NONE;
            end
         end else if (kind_in == KIND_SINGLE) begin
            // single nal unit body
            ub_v = unit_byte(item.in_byte, item.packet_last, cnt_in, limit,
                             cfg.emit_start_codes);
            el_v[n_v[0]] = ub_v.el;
            n_v = n_v + 2'd1;
            cnt_in = ub_v.cnt;
            if (!ub_v.ok) kind_in = KIND_NONE;
         end else if (kind_in == KIND_FRAG) begin
            if (pos_in == 2'd1) begin
               hdr2_in = item.in_byte;
               pos_in  = 2'd2;
            end else if (pos_in == 2'd2) begin
               // fu header
               pos_in  = HdrDone;
               fend_in = item.in_byte[6];
               if (item.in_byte[7]) begin
                  if (infrag_in) begin
                     el_v[n_v[0]] = close_elem(ST_MALFORMED, cnt_in == '0,
                                               cfg.emit_start_codes);
                     n_v = n_v + 2'd1;
                     cnt_in    = '0;
                     infrag_in = 1'b0;
                     kind_in   = KIND_NONE;
                  end else begin
                     // rebuilt nal header, two bytes
                     infrag_in = 1'b1;
                     ub_v = unit_byte({hdr1_in[7], item.in_byte[5:0], hdr1_in[0]}, 1'b0,
                                      cnt_in, limit, cfg.emit_start_codes);
                     el_v[n_v[0]] = ub_v.el;
                     n_v = n_v + 2'd1;
                     cnt_in = ub_v.cnt;
                     if (ub_v.ok) begin
                        ub2_v = unit_byte(hdr2_in, item.packet_last && item.in_byte[6],
                                          cnt_in, limit, cfg.emit_start_codes);
                        el_v[n_v[0]] = ub2_v.el;
                        n_v = n_v + 2'd1;
                        cnt_in = ub2_v.cnt;
                        fail_v = !ub2_v.ok;
                     end else begin
                        fail_v = 1'b1;
                     end
                     if (fail_v) begin
                        infrag_in = 1'b0;
                        kind_in   = KIND_NONE;
                     end
                  end
               end else if (!infrag_in) begin
                  kind_in = KIND_NONE;
               end
            end else begin
               // fragment payload
               ub_v = unit_byte(item.in_byte, item.packet_last && fend_in, cnt_in, limit,
                                cfg.emit_start_codes);
               el_v[n_v[0]] = ub_v.el;
               n_v = n_v + 2'd1;
               cnt_in = ub_v.cnt;
               if (!ub_v.ok) begin
                  infrag_in = 1'b0;
                  kind_in   = KIND_NONE;
               end
            end
         end else if (kind_in == KIND_AGGR) begin
            if (pos_in == 2'd1) begin
               hdr2_in = item.in_byte;
               pos_in  = 2'd2;
            end else begin
               // aggregation body
               pos_in = HdrDone;
               unique case (phase_in)
                  PH_LEN_HI: begin
                     lenhi_in = item.in_byte;
                     phase_in = PH_LEN_LO;
                  end
                  PH_LEN_LO: begin
                     if ({lenhi_in, item.in_byte} == 16'd0) begin
                        el_v[n_v[0]] = close_elem(ST_OK, cnt_in == '0, cfg.emit_start_codes);
                        n_v = n_v + 2'd1;
                        cnt_in   = '0;
                        phase_in = PH_LEN_HI;
                     end else begin
                        rem_in   = {lenhi_in, item.in_byte};
                        phase_in = PH_DATA;
                     end
                  end
                  PH_DATA: begin
                     ub_v = unit_byte(item.in_byte, rem_in == 16'd1, cnt_in, limit,
                                      cfg.emit_start_codes);
                     el_v[n_v[0]] = ub_v.el;
                     n_v = n_v + 2'd1;
                     cnt_in = ub_v.cnt;
                     rem_in = rem_in - 16'd1;
                     if (rem_in == 16'd0) phase_in = PH_LEN_HI;
                     else if (!ub_v.ok) phase_in = PH_SKIP;
                  end
                  default: begin
                     rem_in = rem_in - 16'd1;
                     if (rem_in == 16'd0) phase_in = PH_LEN_HI;
                  end
               endcase
            end
         end

         // packet end
         if (item.packet_last) begin
            if (kind_in == KIND_FRAG) begin
               if (pos_in < HdrDone) begin
                  el_v[n_v[0]] = close_elem(ST_MALFORMED, cnt_in == '0, cfg.emit_start_codes);
                  n_v = n_v + 2'd1;
                  cnt_in    = '0;
                  infrag_in = 1'b0;
               end else if (infrag_in && fend_in) begin
                  if (cnt_in != '0) begin
                     el_v[n_v[0]] = close_elem(ST_OK, 1'b0, cfg.emit_start_codes);
                     n_v = n_v + 2'd1;
                     cnt_in = '0;
                  end
                  infrag_in = 1'b0;
               end
            end else if (kind_in == KIND_AGGR) begin
               if (pos_in < HdrDone || phase_in == PH_LEN_LO || phase_in == PH_DATA) begin
                  el_v[n_v[0]] = close_elem(ST_MALFORMED, cnt_in == '0, cfg.emit_start_codes);
                  n_v = n_v + 2'd1;
                  cnt_in = '0;
               end
            end
            kind_in  = KIND_NONE;
            pos_in   = 2'd0;
            phase_in = PH_LEN_HI;
            rem_in   = '0;
            if (!infrag_in) cnt_in = '0;
         end
      end
   end

   // queue write
   assign q_push      = accept && (n_v != 2'd0);
   assign q_entry.two = n_v[1];
   assign q_entry.e1  = el_v[1];
   assign q_entry.e0  = el_v[0];

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff   <= KIND_NONE;
         pos_ff    <= 2'd0;
         hdr1_ff   <= '0;
         hdr2_ff   <= '0;
         infrag_ff <= 1'b0;
         fend_ff   <= 1'b0;
         phase_ff  <= PH_LEN_HI;
         rem_ff    <= '0;
         lenhi_ff  <= '0;
         cnt_ff    <= '0;
      end else if (accept) begin
         kind_ff   <= kind_in;
         pos_ff    <= pos_in;
         hdr1_ff   <= hdr1_in;
         hdr2_ff   <= hdr2_in;
         infrag_ff <= infrag_in;
         fend_ff   <= fend_in;
         phase_ff  <= phase_in;
         rem_ff    <= rem_in;
         lenhi_ff  <= lenhi_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule
`default_nettype wire

[rtl/hevcrtp_queue.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// hevcrtp_queue: entry queue between parser and expander
// Small register queue holding the elements of a few input bytes.
// ---------------------------------------------------------------------------
module hevcrtp_queue (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               wr_en,
   input  hevcrtp_pkg::hevcrtp_entry_type    wr_entry,
   output logic                              full,
   input  wire                               rd_en,
   output hevcrtp_pkg::hevcrtp_entry_type    rd_entry,
   output logic                              empty
);
   import hevcrtp_pkg::*;

   localparam int PtrW = $clog2(QUEUE_DEPTH);
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   hevcrtp_entry_type  slot_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]    wptr_ff, rptr_ff;
   logic [CntW-1:0]    count_ff, count_in;
   logic               do_wr, do_rd;

   assign full     = (count_ff == CntW'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign rd_entry = slot_ff[rptr_ff];
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && !empty;

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (do_wr && !do_rd) count_in = count_ff + 1'b1;
      else if (do_rd && !do_wr) count_in = count_ff - 1'b1;
   end

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (do_wr) wptr_ff <= wptr_ff + 1'b1;
         if (do_rd) rptr_ff <= rptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_wr) slot_ff[wptr_ff] <= wr_entry;
   end

endmodule
`default_nettype wire

[rtl/hevcrtp_back.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// hevcrtp_back: result expander
// Walks the head entry one result per cycle into a registered result stage,
// inserting start code bytes, while that stage is empty or being popped.
// ---------------------------------------------------------------------------
module hevcrtp_back (
   input  wire                               clock,
   input  wire                               reset,
   input  hevcrtp_pkg::hevcrtp_entry_type    head,
   input  wire                               q_empty,
   output logic                              q_pop,
   output hevcrtp_pkg::hevcrtp_rsp_type      rsp_item,
   output logic                              empty,
   input  wire                               pop
);
   import hevcrtp_pkg::*;

   localparam int SubW = $clog2(START_CODE_BYTES + 1);

   logic               idx_ff;
   logic [SubW-1:0]    sub_ff;
   logic               out_valid_ff;
   hevcrtp_rsp_type    out_ff, out_in;
   hevcrtp_elem_type   el;
   logic               in_sc;
   logic               el_done;
   logic               entry_done;
   logic               advance;

   assign el         = idx_ff ? head.e1 : head.e0;
   assign in_sc      = el.sc && (sub_ff != SubW'(START_CODE_BYTES));
   assign el_done    = !in_sc;
   assign entry_done = el_done && (idx_ff || !head.two);
   assign advance    = !q_empty && (!out_valid_ff || pop);
   assign q_pop      = advance && entry_done;

   // next result from the head element
   always_comb begin
      if (in_sc) begin
         out_in.out_byte   = sc_byte(sub_ff[1:0]);
         out_in.byte_valid = 1'b1;
         out_in.unit_first = (sub_ff == '0);
         out_in.unit_last  = 1'b0;
         out_in.status     = ST_OK;
      end else begin
         out_in.out_byte   = el.data;
         out_in.byte_valid = el.valid;
         out_in.unit_first = el.first;
         out_in.unit_last  = el.last;
         out_in.status     = el.status;
      end
      out_in.run_last = entry_done;
   end

   // walk position and output stage
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 1'b0;
         sub_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
         if (el_done) begin
            sub_ff <= '0;
            idx_ff <= !entry_done;
         end else begin
            sub_ff <= sub_ff + 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) out_ff <= out_in;
   end

   assign rsp_item = out_ff;
   assign empty    = !out_valid_ff;

endmodule
`default_nettype wire
